// File: hdl/cvg_pkg.sv
package cvg_pkg;

  // Circle resolution and item field widths.
  localparam int SEGMENTS = 72;
  localparam int IDX_W = 7;
  localparam int ROM_DEPTH = 1 << IDX_W;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 3'd6;

  // Fixed point constants.
  localparam logic [63:0] SEG64 = 64'(SEGMENTS);
  localparam logic [63:0] OCT_DIV = 64'(4 * SEGMENTS);
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [31:0] NY_LIMIT = 32'd1063004406;
  localparam logic signed [31:0] UNIT_POS = 32'sd1073741824;
  localparam logic signed [31:0] UNIT_NEG = -32'sd1073741824;
  localparam logic [63:0] SIN_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
  localparam logic [63:0] COS_DIV [6] = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12, 64'd2};

  // Basis builder sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_DIV,
    ST_PICK,
    ST_CROSS
  } basis_state_t;

  // Plane basis handed from the basis builder to the vertex pipeline.
  typedef struct packed {
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] uz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic               degenerate;
  } basis_t;

  typedef logic [31:0] trig_rom_t [ROM_DEPTH];

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // Round a Q2.30 value to Q1.15, half away from zero, +1.0 saturating.
  function automatic logic [15:0] to_q15(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    q = (mag + (64'd1 << 14)) >> 15;
    if (v >= 0) begin
      return (q > 64'd32767) ? 16'd32767 : q[15:0];
    end
    return 16'(-q[15:0]);
  endfunction

  // One table entry: cosine in the upper half, sine in the lower half.
  function automatic logic [31:0] trig_entry(input int unsigned idx);
    logic [63:0] i, m, oct, rem, r, x, x2, t, s, c, tmp;
    logic signed [63:0] cs, sn;
    i = 64'(idx) % SEG64;
    m = 64'd8 * i;
    oct = m / SEG64;
    rem = m % SEG64;
    r = oct[0] ? (SEG64 - rem) : rem;
    x = (r * PI_Q30 + 64'd2 * SEG64) / OCT_DIV;
    x2 = mul_q30(x, x);
    t = Q30_ONE;
    for (int k = 0; k < 5; k++) begin
      t = Q30_ONE - mul_q30(x2, t) / SIN_DIV[k];
    end
    s = mul_q30(x, t);
    t = Q30_ONE;
    for (int k = 0; k < 6; k++) begin
      t = Q30_ONE - mul_q30(x2, t) / COS_DIV[k];
    end
    c = t;
    if (oct[0]) begin
      tmp = s;
      s = c;
      c = tmp;
    end
    case (oct[2:1])
      2'd0: begin cs = $signed(c); sn = $signed(s); end
      2'd1: begin cs = -$signed(s); sn = $signed(c); end
      2'd2: begin cs = -$signed(c); sn = -$signed(s); end
      default: begin cs = $signed(s); sn = -$signed(c); end
    endcase
    return {to_q15(cs), to_q15(sn)};
  endfunction

  function automatic trig_rom_t build_trig_rom();
    trig_rom_t rom;
    for (int j = 0; j < ROM_DEPTH; j++) begin
      rom[j] = trig_entry(j);
    end
    return rom;
  endfunction

  localparam trig_rom_t TRIG_ROM = build_trig_rom();

  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

endpackage

// File: hdl/circle_vertex_generator_3d.sv
// Circle vertex generator: for each segment index it returns one vertex of a circle of the
// configured centre and radius lying in the plane of the configured normal, in signed Q16.16.
// The vertex pipeline takes one transaction per cycle unless in_stall is high, through table
// lookup, radius scaling, projection, sum and output register stages; new transactions enter
// while a result waits only until the earlier stages fill. After reset and after every normal
// register write, a sequential basis builder (one shared 32x32 multiplier, a one-step-per-cycle
// square root and a one-bit-per-cycle divider) recomputes the plane basis, ending early for a
// zero normal, and in_stall stays high during that time. Configuration writes are always taken.
module circle_vertex_generator_3d (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cvg_pkg::IDX_W-1:0]     in_segment_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_vertex_x,
  output logic signed [31:0]            out_vertex_y,
  output logic signed [31:0]            out_vertex_z,
  output logic                          out_degenerate,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cvg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import cvg_pkg::*;

  logic signed [31:0] center_x_r, center_y_r, center_z_r;
  logic signed [31:0] normal_x_r, normal_y_r, normal_z_r;
  logic [30:0] radius_r;
  logic cfg_wr, normal_wr, busy;
  basis_t basis;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      radius_r <= 31'd65536;
      normal_x_r <= '0;
      normal_y_r <= '0;
      normal_z_r <= 32'sd65536;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_CENTER_X: center_x_r <= cfg_data;
        CFG_CENTER_Y: center_y_r <= cfg_data;
        CFG_CENTER_Z: center_z_r <= cfg_data;
        CFG_RADIUS: begin
          // A zero radius write is ignored.
          if (cfg_data[30:0] != 31'd0) radius_r <= cfg_data[30:0];
        end
        CFG_NORMAL_X: normal_x_r <= cfg_data;
        CFG_NORMAL_Y: normal_y_r <= cfg_data;
        CFG_NORMAL_Z: normal_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A new normal triggers a rebuild of the plane basis.
  always_comb begin
    case (cfg_index)
      CFG_NORMAL_X, CFG_NORMAL_Y, CFG_NORMAL_Z: normal_wr = cfg_wr;
      default: normal_wr = 1'b0;
    endcase
  end

  cvg_basis u_basis (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (normal_wr),
    .normal_x (normal_x_r),
    .normal_y (normal_y_r),
    .normal_z (normal_z_r),
    .busy     (busy),
    .basis    (basis)
  );

  cvg_pipe u_pipe (
    .clk              (clk),
    .rst_n            (rst_n),
    .busy             (busy),
    .basis            (basis),
    .center_x         (center_x_r),
    .center_y         (center_y_r),
    .center_z         (center_z_r),
    .radius           (radius_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_segment_index (in_segment_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_vertex_x     (out_vertex_x),
    .out_vertex_y     (out_vertex_y),
    .out_vertex_z     (out_vertex_z),
    .out_degenerate   (out_degenerate)
  );

endmodule

// File: hdl/cvg_basis.sv
module cvg_basis (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic signed [31:0] normal_z,
  output logic               busy,
  output cvg_pkg::basis_t    basis
);
  import cvg_pkg::*;

  basis_state_t state_r, state_nxt;
  logic [4:0] cnt_r;
  logic [1:0] comp_r, comp_inc;
  logic pass_r, degen_r;

  logic signed [31:0] nrm [3];
  logic signed [31:0] src [3];
  logic signed [31:0] n_r [3];
  logic signed [31:0] u_r [3];
  logic signed [31:0] v_r [3];

  logic [63:0] acc_r, rest_r, root_r, bit_r, sq_sum, root_nxt;
  logic [64:0] trial;
  logic root_ge;
  logic [31:0] len_r;
  logic [32:0] rem_r, div_rem;
  logic [30:0] q_r, q_nxt;
  logic div_ge;
  logic signed [31:0] div_unit, mul_a, mul_b;
  logic signed [63:0] prod_r, tmp_r, cross_d, cross_sh;
  logic signed [31:0] cross_clamp;

  assign nrm[0] = normal_x;
  assign nrm[1] = normal_y;
  assign nrm[2] = normal_z;

  // The first pass works on the raw normal, the second on the raw u vector.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      src[c] = pass_r ? u_r[c] : nrm[c];
    end
  end

  assign comp_inc = (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ: begin
        case (cnt_r)
          5'd0: begin mul_a = src[0]; mul_b = src[0]; end
          5'd1: begin mul_a = src[1]; mul_b = src[1]; end
          5'd2: begin mul_a = src[2]; mul_b = src[2]; end
          default: ;
        endcase
      end
      ST_CROSS: begin
        case (cnt_r)
          5'd0: begin mul_a = n_r[1]; mul_b = u_r[2]; end
          5'd1: begin mul_a = n_r[2]; mul_b = u_r[1]; end
          5'd2: begin mul_a = n_r[2]; mul_b = u_r[0]; end
          5'd3: begin mul_a = n_r[0]; mul_b = u_r[2]; end
          5'd4: begin mul_a = n_r[0]; mul_b = u_r[1]; end
          5'd5: begin mul_a = n_r[1]; mul_b = u_r[0]; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Sum of squares, one square root step, one divide step and the clamped cross product term.
  always_comb begin
    sq_sum = acc_r + $unsigned(prod_r);
    trial = {1'b0, root_r} + {1'b0, bit_r};
    root_ge = {1'b0, rest_r} >= trial;
    root_nxt = root_ge ? ((root_r >> 1) + bit_r) : (root_r >> 1);
    div_ge = rem_r >= {1'b0, len_r};
    div_rem = div_ge ? (rem_r - {1'b0, len_r}) : rem_r;
    q_nxt = {q_r[29:0], div_ge};
    if (len_r == 32'd0) begin
      div_unit = '0;
    end else if (src[comp_r][31]) begin
      div_unit = -$signed({1'b0, q_nxt});
    end else begin
      div_unit = $signed({1'b0, q_nxt});
    end
    cross_d = tmp_r - prod_r;
    cross_sh = cross_d >>> 30;
    if (cross_sh > 64'(UNIT_POS)) begin
      cross_clamp = UNIT_POS;
    end else if (cross_sh < 64'(UNIT_NEG)) begin
      cross_clamp = UNIT_NEG;
    end else begin
      cross_clamp = cross_sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SQ;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: ;
      ST_SQ: begin
        if (cnt_r == 5'd3) begin
          state_nxt = (!pass_r && sq_sum == 64'd0) ? ST_IDLE : ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (cnt_r == 5'd31) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == 5'd30 && comp_r == 2'd2) begin
          state_nxt = pass_r ? ST_CROSS : ST_PICK;
        end
      end
      ST_PICK: state_nxt = ST_SQ;
      ST_CROSS: begin
        if (cnt_r == 5'd6) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (start) begin
      state_nxt = ST_SQ;
    end
  end

  assign busy = (state_r != ST_IDLE);

  // Step counters and pass control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      comp_r <= '0;
      pass_r <= 1'b0;
      degen_r <= 1'b0;
    end else if (start) begin
      cnt_r <= '0;
      comp_r <= '0;
      pass_r <= 1'b0;
    end else begin
      case (state_r)
        ST_SQ: begin
          cnt_r <= (cnt_r == 5'd3) ? 5'd0 : cnt_r + 5'd1;
          if (cnt_r == 5'd3 && !pass_r) begin
            degen_r <= (sq_sum == 64'd0);
          end
        end
        ST_ROOT: cnt_r <= cnt_r + 5'd1;
        ST_DIV: begin
          if (cnt_r == 5'd30) begin
            cnt_r <= '0;
            comp_r <= comp_inc;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_PICK: begin
          pass_r <= 1'b1;
          cnt_r <= '0;
        end
        ST_CROSS: cnt_r <= (cnt_r == 5'd6) ? 5'd0 : cnt_r + 5'd1;
        default: cnt_r <= '0;
      endcase
    end
  end

  // Datapath registers of the shared multiplier, root and divide units.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_SQ: begin
        acc_r <= (cnt_r == 5'd0) ? 64'd0 : sq_sum;
        if (cnt_r == 5'd3) begin
          rest_r <= sq_sum;
          root_r <= '0;
          bit_r <= 64'd1 << 62;
        end
      end
      ST_ROOT: begin
        rest_r <= root_ge ? (rest_r - trial[63:0]) : rest_r;
        root_r <= root_nxt;
        bit_r <= bit_r >> 2;
        if (cnt_r == 5'd31) begin
          len_r <= root_nxt[31:0];
          rem_r <= {1'b0, mag32(src[0])};
          q_r <= '0;
        end
      end
      ST_DIV: begin
        rem_r <= {div_rem[31:0], 1'b0};
        q_r <= q_nxt;
        if (cnt_r == 5'd30) begin
          if (pass_r) begin
            u_r[comp_r] <= div_unit;
          end else begin
            n_r[comp_r] <= div_unit;
          end
          rem_r <= {1'b0, mag32(src[comp_inc])};
          q_r <= '0;
        end
      end
      ST_PICK: begin
        // Use (0,1,0) x n unless n is nearly along y, then n x (1,0,0).
        if (mag32(n_r[1]) < NY_LIMIT) begin
          u_r[0] <= n_r[2];
          u_r[1] <= '0;
          u_r[2] <= -n_r[0];
        end else begin
          u_r[0] <= '0;
          u_r[1] <= n_r[2];
          u_r[2] <= -n_r[1];
        end
      end
      ST_CROSS: begin
        if (cnt_r[0]) begin
          tmp_r <= prod_r;
        end else if (cnt_r != 5'd0) begin
          v_r[cnt_r[2:1] - 2'd1] <= cross_clamp;
        end
      end
      default: ;
    endcase
  end

  assign basis = '{ux: u_r[0], uy: u_r[1], uz: u_r[2],
                   vx: v_r[0], vy: v_r[1], vz: v_r[2], degenerate: degen_r};

  a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !start) |=> $stable(basis))
    else $error("basis changed while idle");

  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (state_r == ST_SQ && !pass_r && cnt_r == 5'd0))
    else $error("normal write did not restart the basis build");

  a_v_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CROSS && cnt_r == 5'd6) |=>
      (basis.vz <= UNIT_POS && basis.vz >= UNIT_NEG))
    else $error("v component out of unit range");

endmodule

// File: hdl/cvg_pipe.sv
module cvg_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       busy,
  input  cvg_pkg::basis_t            basis,
  input  logic signed [31:0]         center_x,
  input  logic signed [31:0]         center_y,
  input  logic signed [31:0]         center_z,
  input  logic [30:0]                radius,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cvg_pkg::IDX_W-1:0]  in_segment_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         out_vertex_x,
  output logic signed [31:0]         out_vertex_y,
  output logic signed [31:0]         out_vertex_z,
  output logic                       out_degenerate
);
  import cvg_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5, accept;

  logic signed [15:0] cq_r, sq_r;
  logic signed [32:0] rc_r, rs_r;
  logic signed [47:0] rc_full, rs_full;
  logic signed [31:0] rad_s;
  logic signed [31:0] uvec [3];
  logic signed [31:0] vvec [3];
  logic signed [31:0] cen [3];
  logic signed [64:0] pu_r [3];
  logic signed [64:0] pv_r [3];
  logic signed [65:0] s4_r [3];
  logic signed [65:0] s4_nxt [3];
  logic signed [65:0] s_sh [3];
  logic signed [36:0] pos [3];
  logic signed [31:0] vtx_nxt [3];
  logic signed [31:0] vtx_r [3];
  logic degen_r;

  assign uvec[0] = basis.ux;
  assign uvec[1] = basis.uy;
  assign uvec[2] = basis.uz;
  assign vvec[0] = basis.vx;
  assign vvec[1] = basis.vy;
  assign vvec[2] = basis.vz;
  assign cen[0] = center_x;
  assign cen[1] = center_y;
  assign cen[2] = center_z;

  // Each stage loads when it is empty or its successor loads.
  assign en5 = !v5_r || !out_stall;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = busy || !en1;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= accept;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Radius scaling of cosine and sine, rounded back to Q16.16.
  always_comb begin
    rad_s = $signed({1'b0, radius});
    rc_full = rad_s * cq_r + 48'sd16384;
    rs_full = rad_s * sq_r + 48'sd16384;
  end

  // Final rounding shift, centre offset and saturation, or the centre for a degenerate basis.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s4_nxt[c] = 66'(pu_r[c]) + 66'(pv_r[c]) + 66'sd536870912;
      s_sh[c] = s4_r[c] >>> 30;
      pos[c] = s_sh[c][36:0] + 37'(cen[c]);
      if (basis.degenerate) begin
        vtx_nxt[c] = cen[c];
      end else if (pos[c] > 37'sd2147483647) begin
        vtx_nxt[c] = 32'sh7fffffff;
      end else if (pos[c] < -37'sd2147483648) begin
        vtx_nxt[c] = 32'sh80000000;
      end else begin
        vtx_nxt[c] = pos[c][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    // Stage 1: table lookup.
    if (en1 && accept) begin
      cq_r <= TRIG_ROM[in_segment_index][31:16];
      sq_r <= TRIG_ROM[in_segment_index][15:0];
    end
    // Stage 2: radius times cosine and sine.
    if (en2 && v1_r) begin
      rc_r <= rc_full[47:15];
      rs_r <= rs_full[47:15];
    end
    // Stage 3: projection onto the plane basis.
    if (en3 && v2_r) begin
      for (int c = 0; c < 3; c++) begin
        pu_r[c] <= rc_r * uvec[c];
        pv_r[c] <= rs_r * vvec[c];
      end
    end
    // Stage 4: sum of the two projections with rounding bias.
    if (en4 && v3_r) begin
      for (int c = 0; c < 3; c++) begin
        s4_r[c] <= s4_nxt[c];
      end
    end
    // Stage 5: output register.
    if (en5 && v4_r) begin
      for (int c = 0; c < 3; c++) begin
        vtx_r[c] <= vtx_nxt[c];
      end
      degen_r <= basis.degenerate;
    end
  end

  assign out_valid = v5_r;
  assign out_vertex_x = vtx_r[0];
  assign out_vertex_y = vtx_r[1];
  assign out_vertex_z = vtx_r[2];
  assign out_degenerate = degen_r;

  a_degen_centre: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_vertex_x == center_x && out_vertex_y == center_y && out_vertex_z == center_z))
    else $error("degenerate vertex differs from centre");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v1_r)
    else $error("accepted transaction did not enter the pipeline");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !en4) |=> (v4_r && $stable(s4_r[0])))
    else $error("stalled stage lost its transaction");

endmodule

// File: bench/tb_circle_vertex_generator_3d.sv
`timescale 1ns / 100ps

module tb_circle_vertex_generator_3d;
  import cvg_pkg::*;

  // Register index past the end of the list; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 1050;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               degen;
  } vertex_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [IDX_W-1:0]     in_segment_index;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [31:0]   out_vertex_x;
  logic signed [31:0]   out_vertex_y;
  logic signed [31:0]   out_vertex_z;
  logic                 out_degenerate;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  // Shadow copy of the configuration registers.
  logic signed [31:0] sh_center [3];
  logic [30:0]        sh_radius;
  logic signed [31:0] sh_normal [3];

  vertex_t pending_vertices [$];
  int      error_count;
  int      hold_cycles;
  bit      recv_busy;

  circle_vertex_generator_3d dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_segment_index(in_segment_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_vertex_x(out_vertex_x), .out_vertex_y(out_vertex_y),
    .out_vertex_z(out_vertex_z), .out_degenerate(out_degenerate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Vertex predictor
  // ---------------------------------------------------------------------------

  function automatic longint unsigned abs64(longint signed a);
    return (a < 0) ? longint'(-a) : longint'(a);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned rest, root, bitv;
    rest = x;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rest) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rest >= root + bitv) begin
        rest = rest - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Divide a component by the vector length, giving Q2.30 truncated toward zero.
  function automatic longint signed scale_unit(longint signed c, longint unsigned len);
    longint unsigned q;
    if (len == 0) return 0;
    q = (abs64(c) << 30) / len;
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic int round_q15(longint signed v);
    longint unsigned q;
    q = (abs64(v) + (64'd1 << 14)) >> 15;
    if (v >= 0) return (q > 32767) ? 32767 : int'(q);
    return -int'(q);
  endfunction

  // Cosine and sine of 2*pi*idx/SEGMENTS in Q1.15, built by octant folding.
  task automatic angle_cos_sin(input int idx, output int cq, output int sq);
    longint unsigned sine_div [5];
    longint unsigned cosine_div [6];
    longint unsigned seg, m, oct, rem, r, x, x2, t, s, c, tmp;
    longint signed cv, sv;
    sine_div = '{110, 72, 42, 20, 6};
    cosine_div = '{132, 90, 56, 30, 12, 2};
    seg = SEGMENTS;
    m = 8 * (longint'(idx) % seg);
    oct = m / seg;
    rem = m % seg;
    r = oct[0] ? seg - rem : rem;
    x = (r * 64'd3373259426 + 2 * seg) / (4 * seg);
    x2 = q30_mul(x, x);
    t = 64'd1 << 30;
    for (int k = 0; k < 5; k++) t = (64'd1 << 30) - q30_mul(x2, t) / sine_div[k];
    s = q30_mul(x, t);
    t = 64'd1 << 30;
    for (int k = 0; k < 6; k++) t = (64'd1 << 30) - q30_mul(x2, t) / cosine_div[k];
    c = t;
    if (oct[0]) begin
      tmp = s;
      s = c;
      c = tmp;
    end
    case (oct[2:1])
      2'd0: begin cv = c; sv = s; end
      2'd1: begin cv = -longint'(s); sv = c; end
      2'd2: begin cv = -longint'(c); sv = -longint'(s); end
      default: begin cv = s; sv = -longint'(c); end
    endcase
    cq = round_q15(cv);
    sq = round_q15(sv);
  endtask

  function automatic logic signed [31:0] offset_coord(longint signed centre, longint signed rc,
                                                       longint signed rs, longint signed uc,
                                                       longint signed vc);
    longint signed p;
    p = centre + ((rc * uc + rs * vc + (64'sd1 << 29)) >>> 30);
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  task automatic predict_vertex(input int idx, output vertex_t v);
    longint signed nx, ny, nz, ux, uy, uz, vx, vy, vz, rc, rs;
    longint unsigned len, ulen;
    int cq, sq;
    v.x = sh_center[0];
    v.y = sh_center[1];
    v.z = sh_center[2];
    v.degen = 1'b1;
    if (sh_normal[0] == 0 && sh_normal[1] == 0 && sh_normal[2] == 0) return;
    len = int_sqrt(abs64(sh_normal[0]) * abs64(sh_normal[0]) +
                   abs64(sh_normal[1]) * abs64(sh_normal[1]) +
                   abs64(sh_normal[2]) * abs64(sh_normal[2]));
    nx = scale_unit(sh_normal[0], len);
    ny = scale_unit(sh_normal[1], len);
    nz = scale_unit(sh_normal[2], len);
    // Pick the helper axis by how close the normal lies to the y axis.
    if (abs64(ny) < 64'd1063004406) begin
      ux = nz; uy = 0; uz = -nx;
    end else begin
      ux = 0; uy = nz; uz = -ny;
    end
    ulen = int_sqrt(abs64(ux) * abs64(ux) + abs64(uy) * abs64(uy) + abs64(uz) * abs64(uz));
    ux = scale_unit(ux, ulen);
    uy = scale_unit(uy, ulen);
    uz = scale_unit(uz, ulen);
    vx = (ny * uz - nz * uy) >>> 30;
    vy = (nz * ux - nx * uz) >>> 30;
    vz = (nx * uy - ny * ux) >>> 30;
    if (vx > (64'sd1 << 30)) vx = 64'sd1 << 30;
    if (vx < -(64'sd1 << 30)) vx = -(64'sd1 << 30);
    if (vy > (64'sd1 << 30)) vy = 64'sd1 << 30;
    if (vy < -(64'sd1 << 30)) vy = -(64'sd1 << 30);
    if (vz > (64'sd1 << 30)) vz = 64'sd1 << 30;
    if (vz < -(64'sd1 << 30)) vz = -(64'sd1 << 30);
    angle_cos_sin(idx, cq, sq);
    rc = (longint'(sh_radius) * cq + (64'sd1 << 14)) >>> 15;
    rs = (longint'(sh_radius) * sq + (64'sd1 << 14)) >>> 15;
    v.x = offset_coord(sh_center[0], rc, rs, ux, vx);
    v.y = offset_coord(sh_center[1], rc, rs, uy, vy);
    v.z = offset_coord(sh_center[2], rc, rs, uz, vz);
    v.degen = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Monitors and checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Each accepted input transaction queues its predicted vertex.
  always @(posedge clk) begin
    vertex_t v;
    if (rst_n && in_valid && !in_stall) begin
      predict_vertex(int'(in_segment_index), v);
      pending_vertices.insert(pending_vertices.size(), v);
    end
  end

  // Each accepted output transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    vertex_t v;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected result", out_vertex_x, 32'h0);
      end else begin
        v = pending_vertices.pop_front();
        if (out_vertex_x !== v.x) report_mismatch("vertex_x", out_vertex_x, v.x);
        if (out_vertex_y !== v.y) report_mismatch("vertex_y", out_vertex_y, v.y);
        if (out_vertex_z !== v.z) report_mismatch("vertex_z", out_vertex_z, v.z);
        if (out_degenerate !== v.degen) begin
          report_mismatch("degenerate", 32'(out_degenerate), 32'(v.degen));
        end
      end
    end
  end

  // Receiver stalls: a requested long hold first, otherwise random stretches.
  initial begin
    int run;
    out_stall = 1'b0;
    run = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (run > 0) begin
        run--;
      end else if (!recv_busy) begin
        out_stall <= 1'b0;
        run = $urandom_range(0, 40);
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
        run = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_segment(input logic [IDX_W-1:0] idx, input int gap);
    @(negedge clk);
    in_valid <= 1'b1;
    in_segment_index <= idx;
    do @(posedge clk); while (in_stall);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Registers are only written once the pipeline has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CENTER_X: sh_center[0] = data;
      CFG_CENTER_Y: sh_center[1] = data;
      CFG_CENTER_Z: sh_center[2] = data;
      CFG_RADIUS:   if (data[30:0] != 0) sh_radius = data[30:0];
      CFG_NORMAL_X: sh_normal[0] = data;
      CFG_NORMAL_Y: sh_normal[1] = data;
      CFG_NORMAL_Z: sh_normal[2] = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_circle(input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
                            input logic [31:0] rad, input logic [31:0] nx,
                            input logic [31:0] ny, input logic [31:0] nz);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_NORMAL_X, nx);
    write_reg(CFG_NORMAL_Y, ny);
    write_reg(CFG_NORMAL_Z, nz);
  endtask

  // Random 32-bit value leaning toward extremes and modest magnitudes.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      3: return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_reset_circle();
    send_segment(0, 0);
    send_segment(18, 1);
    send_segment(36, 0);
    send_segment(71, 2);
    send_segment(72, 0);
    send_segment(127, 0);
  endtask

  task automatic test_corner_configs();
    // Far corner of the range with the largest radius pushes some axes into saturation.
    set_circle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_segment(0, 0);
    send_segment(9, 0);
    send_segment(45, 0);
    // Normal along y takes the other helper axis.
    set_circle(32'h0002_0000, 32'hFFFF_0000, 0, 32'h0003_0000, 0, 32'h8000_0000, 0);
    send_segment(5, 0);
    send_segment(27, 3);
    // Zero radius writes are dropped, as is a write past the register list.
    write_reg(CFG_RADIUS, 32'h0);
    write_reg(CFG_RADIUS, 32'h8000_0000);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    send_segment(63, 0);
    // Normal at the largest magnitudes on all axes.
    set_circle(0, 0, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_segment(100, 0);
    send_segment(35, 0);
    // Zero normal returns the centre and flags it.
    set_circle(32'h1234_5678, 32'hFEDC_BA98, 32'h8000_0000, 32'h0001_0000, 0, 0, 0);
    send_segment(0, 0);
    send_segment(127, 0);
    // Tiny normal of one LSB.
    write_reg(CFG_NORMAL_Y, 32'h1);
    send_segment(12, 0);
    send_segment(85, 0);
  endtask

  task automatic test_random_circles();
    logic [31:0] ny;
    int sent, chunk;
    bit flat;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      ny = rand_word();
      set_circle(rand_word(), rand_word(), rand_word(), rand_word(),
                 ($urandom_range(0, 3) == 0) ? 32'h0 : rand_word(),
                 ($urandom_range(0, 5) == 0) ? 32'h0 : ny,
                 ($urandom_range(0, 5) == 0) ? 32'h0 : rand_word());
      // Occasionally shrink the x and z normal components, moving it near the y axis when y is large.
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_NORMAL_X, $urandom_range(0, 300));
        write_reg(CFG_NORMAL_Z, 32'(-int'($urandom_range(0, 300))));
      end
      chunk = $urandom_range(40, 110);
      flat = ($urandom_range(0, 3) == 0);
      recv_busy = !flat;
      for (int k = 0; k < chunk; k++) begin
        send_segment(IDX_W'($urandom_range(0, 127)), flat ? 0 : pick_gap());
      end
      recv_busy = 1'b1;
      sent += chunk;
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_cycles = 150;
    for (int k = 0; k < 40; k++) send_segment(IDX_W'($urandom_range(0, 127)), 0);
    // Sender stops until every vertex has come back, then resumes.
    wait_drained();
    for (int k = 0; k < 10; k++) send_segment(IDX_W'($urandom_range(0, 127)), pick_gap());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_segment_index = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    hold_cycles = 0;
    recv_busy = 1'b1;
    sh_center = '{0, 0, 0};
    sh_radius = 31'd65536;
    sh_normal = '{0, 0, 32'sd65536};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_circle();
    test_corner_configs();
    test_backpressure();
    test_random_circles();

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
